[rtl/core/sle_pkg.sv]
// Package for the sequential list engine: sizes, request and status codes,
// and the result type shared by the sequencer and the top level. No dependencies.
package sle_pkg;
    localparam int Depth    = 64;
    localparam int AddrW    = $clog2(Depth);
    localparam int CountW   = $clog2(Depth + 1);
    localparam int DataW    = 32;

    localparam logic [3:0] REQ_PUSH_BACK  = 4'd0;
    localparam logic [3:0] REQ_PUSH_FRONT = 4'd1;
    localparam logic [3:0] REQ_POP_BACK   = 4'd2;
    localparam logic [3:0] REQ_POP_HEAD   = 4'd3;
    localparam logic [3:0] REQ_CLEAR      = 4'd4;
    localparam logic [3:0] REQ_SORT       = 4'd5;
    localparam logic [3:0] REQ_REVERSE    = 4'd6;
    localparam logic [3:0] REQ_SET_AT     = 4'd7;
    localparam logic [3:0] REQ_SET_BY_VAL = 4'd8;
    localparam logic [3:0] REQ_READ_AT    = 4'd9;
    localparam logic [3:0] REQ_FIND       = 4'd10;
    localparam logic [3:0] REQ_LENGTH     = 4'd11;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [2:0]        status;
        logic [DataW-1:0]  read_value;
        logic [6:0]        length;
    } t_result;

    // Memory port bundle from the sequencer to the element store.
    typedef struct packed {
        logic              re;
        logic [AddrW-1:0]  raddr;
        logic              we;
        logic [AddrW-1:0]  waddr;
        logic [DataW-1:0]  wdata;
    } t_mem_req;
endpackage

[rtl/core/sle_store.sv]
// Element store of the list engine: one synchronous RAM, one write and one
// read port, read data registered. Uses sle_pkg.
module sle_store (
    input  logic                           i_clk,
    input  sle_pkg::t_mem_req              i_req,
    output logic [sle_pkg::DataW-1:0]      o_rdata
);
    import sle_pkg::*;

    logic [DataW-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end
endmodule

[rtl/core/sle_seq.sv]
// Request sequencer of the list engine: walks the element store for shifts,
// searches, reverse and bubble sort, and keeps the count. Uses sle_pkg.
module sle_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [3:0]                    i_req_type,
    input  logic [5:0]                    i_position,
    input  logic [sle_pkg::DataW-1:0]     i_value,
    input  logic [sle_pkg::DataW-1:0]     i_replacement,
    input  logic [sle_pkg::DataW-1:0]     i_rdata,
    output sle_pkg::t_mem_req             o_mem,
    output logic                          o_busy,
    output logic                          o_done,
    output sle_pkg::t_result              o_result
);
    import sle_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD_A  = 3'd1;  // first operand back, second read issued
    localparam logic [2:0] S_RD_B  = 3'd2;  // second operand back, first write of a swap
    localparam logic [2:0] S_WR    = 3'd3;  // single-operand walks and read_at
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_WR2   = 3'd5;  // second write: the held value of the pair
    localparam logic [2:0] S_PASS  = 3'd6;  // start of the next sort pass
    localparam logic [2:0] S_HEAD  = 3'd7;  // place the new head of a push front

    logic [2:0]        r_state, n_state;
    logic [CountW-1:0] r_count, n_count;
    logic [3:0]        r_req;
    logic [DataW-1:0]  r_val, r_rep;
    logic [CountW-1:0] r_i, n_i;     // walk index
    logic [CountW-1:0] r_j, n_j;     // upper index / sort pass limit
    logic [DataW-1:0]  r_a, n_a;     // held first operand
    logic              r_swapped, n_swapped;
    t_result           r_res, n_res;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_i       = r_i;
        n_j       = r_j;
        n_a       = r_a;
        n_swapped = r_swapped;
        n_res     = r_res;
        o_mem     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_res = '{status: ST_OK, read_value: '0, length: 7'(r_count)};
                    n_state = S_DONE;
                    n_i = '0;
                    case (i_req_type)
                        REQ_PUSH_BACK: begin
                            if (r_count == CountW'(Depth)) n_res.status = ST_FULL;
                            else begin
                                o_mem.we = 1'b1;
                                o_mem.waddr = r_count[AddrW-1:0];
                                o_mem.wdata = i_value;
                                n_count = r_count + 1'b1;
                            end
                        end
                        REQ_PUSH_FRONT: begin
                            if (r_count == CountW'(Depth)) n_res.status = ST_FULL;
                            else if (r_count == '0) begin
                                o_mem.we = 1'b1;
                                o_mem.waddr = '0;
                                o_mem.wdata = i_value;
                                n_count = r_count + 1'b1;
                            end else begin
                                // Walk downward: read i-1, write i.
                                n_i = r_count;
                                o_mem.re = 1'b1;
                                o_mem.raddr = AddrW'(r_count - 1'b1);
                                n_state = S_WR;
                            end
                        end
                        REQ_POP_BACK: begin
                            if (r_count == '0) n_res.status = ST_EMPTY;
                            else n_count = r_count - 1'b1;
                        end
                        REQ_POP_HEAD: begin
                            if (r_count == '0) n_res.status = ST_EMPTY;
                            else if (r_count == CountW'(1)) n_count = '0;
                            else begin
                                o_mem.re = 1'b1;
                                o_mem.raddr = AddrW'(1);
                                n_state = S_WR;
                            end
                        end
                        REQ_CLEAR: begin
                            if (r_count == '0) n_res.status = ST_EMPTY;
                            else n_count = '0;
                        end
                        REQ_SORT: begin
                            if (r_count > CountW'(1)) begin
                                n_j = r_count - 1'b1;   // compares in this pass
                                n_swapped = 1'b0;
                                o_mem.re = 1'b1;
                                o_mem.raddr = '0;
                                n_state = S_RD_A;
                            end
                        end
                        REQ_REVERSE: begin
                            if (r_count > CountW'(1)) begin
                                n_j = r_count - 1'b1;
                                o_mem.re = 1'b1;
                                o_mem.raddr = '0;
                                n_state = S_RD_A;
                            end
                        end
                        REQ_SET_AT: begin
                            if (r_count == '0) n_res.status = ST_EMPTY;
                            else if (CountW'(i_position) >= r_count)
                                n_res.status = ST_BADPOS;
                            else begin
                                o_mem.we = 1'b1;
                                o_mem.waddr = AddrW'(i_position);
                                o_mem.wdata = i_value;
                            end
                        end
                        REQ_SET_BY_VAL, REQ_FIND: begin
                            if (r_count == '0) n_res.status = ST_NOTFOUND;
                            else begin
                                o_mem.re = 1'b1;
                                o_mem.raddr = '0;
                                n_state = S_WR;
                            end
                        end
                        REQ_READ_AT: begin
                            if (CountW'(i_position) >= r_count)
                                n_res.status = ST_BADPOS;
                            else begin
                                o_mem.re = 1'b1;
                                o_mem.raddr = AddrW'(i_position);
                                n_state = S_WR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_A: begin
                // First operand (index i) is on the read port; fetch j-side.
                n_a = i_rdata;
                o_mem.re = 1'b1;
                if (r_req == REQ_SORT) o_mem.raddr = AddrW'(r_i + 1'b1);
                else o_mem.raddr = AddrW'(r_j);
                n_state = S_RD_B;
            end
            S_RD_B: begin
                if (r_req == REQ_SORT) begin
                    if ($signed(r_a) > $signed(i_rdata)) begin
                        o_mem.we = 1'b1;
                        o_mem.waddr = AddrW'(r_i);
                        o_mem.wdata = i_rdata;
                        n_swapped = 1'b1;
                        n_state = S_WR2;
                    end else begin
                        n_a = i_rdata;  // carry larger value forward
                        n_state = S_WR2;
                    end
                end else begin
                    // Reverse: write i with j's value, then j with held value.
                    o_mem.we = 1'b1;
                    o_mem.waddr = AddrW'(r_i);
                    o_mem.wdata = i_rdata;
                    n_state = S_WR2;
                end
            end
            S_WR2: begin
                if (r_req == REQ_SORT) begin
                    // r_a holds the larger of the pair; it belongs at i+1.
                    o_mem.we = 1'b1;
                    o_mem.waddr = AddrW'(r_i + 1'b1);
                    o_mem.wdata = r_a;
                    if (r_i + 1'b1 >= r_j) begin
                        if (r_j == CountW'(1) || !r_swapped) n_state = S_DONE;
                        else begin
                            // Next pass restarts at entry zero after this write lands.
                            n_j = r_j - 1'b1;
                            n_i = '0;
                            n_swapped = 1'b0;
                            n_state = S_PASS;
                        end
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_RD_B;
                        o_mem.re = 1'b1;
                        o_mem.raddr = AddrW'(r_i + 2'd2);
                    end
                end else begin
                    o_mem.we = 1'b1;
                    o_mem.waddr = AddrW'(r_j);
                    o_mem.wdata = r_a;
                    if (r_i + 2'd2 >= r_j) n_state = S_DONE;
                    else begin
                        n_i = r_i + 1'b1;
                        n_j = r_j - 1'b1;
                        o_mem.re = 1'b1;
                        o_mem.raddr = AddrW'(r_i + 1'b1);
                        n_state = S_RD_A;
                    end
                end
            end
            S_PASS: begin
                o_mem.re = 1'b1;
                o_mem.raddr = '0;
                n_state = S_RD_A;
            end
            S_WR: begin
                // Single-operand walks: shifts, searches and read_at.
                case (r_req)
                    REQ_PUSH_FRONT: begin
                        o_mem.we = 1'b1;
                        o_mem.waddr = AddrW'(r_i);
                        o_mem.wdata = i_rdata;
                        if (r_i == CountW'(1)) n_state = S_HEAD;
                        else begin
                            n_i = r_i - 1'b1;
                            o_mem.re = 1'b1;
                            o_mem.raddr = AddrW'(r_i - 2'd2);
                        end
                    end
                    REQ_POP_HEAD: begin
                        o_mem.we = 1'b1;
                        o_mem.waddr = AddrW'(r_i);
                        o_mem.wdata = i_rdata;
                        if (r_i + 2'd2 >= r_count) begin
                            n_count = r_count - 1'b1;
                            n_res.length = 7'(r_count - 1'b1);
                            n_state = S_DONE;
                        end else begin
                            n_i = r_i + 1'b1;
                            o_mem.re = 1'b1;
                            o_mem.raddr = AddrW'(r_i + 2'd2);
                        end
                    end
                    REQ_READ_AT: begin
                        n_res.read_value = i_rdata;
                        n_state = S_DONE;
                    end
                    default: begin   // set_by_value and find
                        if (i_rdata == r_val) begin
                            if (r_req == REQ_FIND) n_res.read_value = i_rdata;
                            else begin
                                o_mem.we = 1'b1;
                                o_mem.waddr = AddrW'(r_i);
                                o_mem.wdata = r_rep;
                            end
                            n_state = S_DONE;
                        end else if (r_i + 1'b1 >= r_count) begin
                            n_res.status = ST_NOTFOUND;
                            n_state = S_DONE;
                        end else begin
                            n_i = r_i + 1'b1;
                            o_mem.re = 1'b1;
                            o_mem.raddr = AddrW'(r_i + 1'b1);
                        end
                    end
                endcase
            end
            S_HEAD: begin
                o_mem.we = 1'b1;
                o_mem.waddr = '0;
                o_mem.wdata = r_val;
                n_count = r_count + 1'b1;
                n_res.length = 7'(r_count + 1'b1);
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_IDLE && i_start) n_res.length = 7'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_i       <= n_i;
        r_j       <= n_j;
        r_a       <= n_a;
        r_swapped <= n_swapped;
        r_res     <= n_res;
        if (r_state == S_IDLE && i_start) begin
            r_req <= i_req_type;
            r_val <= i_value;
            r_rep <= i_replacement;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = r_res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(Depth)) else $error("count above depth");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !o_mem.we) else $error("write after completion");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double completion");
    a_len_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.length == 7'(r_count))) else $error("length mismatch");
endmodule

[rtl/core/sequential_list_engine.sv]
// Top level of the sequential list engine: request sequencer, element store
// and a one-entry result register. Uses sle_pkg, sle_seq and sle_store.
//
// Usage: a request transfer on the input channel (i_valid high, o_stall low)
// carries the request type, a position, a value and a replacement. Every
// request produces exactly one result transfer with a status, a read value
// and the element count after the request.
// Simple requests (push back, pops from the back, clear, set at, length)
// complete without a walk; read at waits for one read of the store. Shifts,
// find and modify by value walk the store one entry per cycle. Reverse swaps
// pairs from both ends inward. Sort is a bubble sort with early exit, one
// compare of adjacent entries at a time. The single read and single write
// port of the element store set the pace of these walks.
// One request is worked at a time; the next one is taken once the sequencer
// is idle and the output register is empty or being drained in that cycle.
// Reset clears the count and the control state; the store needs no clearing
// since entries at or above the count are never read.
// While the output is stalled, the result holds and new requests are held off
// once the output register is full.
module sequential_list_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [3:0]                  i_req_type,
    input  logic [5:0]                  i_position,
    input  logic signed [31:0]          i_value,
    input  logic signed [31:0]          i_replacement,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_status,
    output logic signed [31:0]          o_read_value,
    output logic [6:0]                  o_length
);
    import sle_pkg::*;

    t_mem_req         mem_req;
    logic [DataW-1:0] rdata;
    logic             busy, done;
    t_result          res;
    logic             start;
    logic             r_out_valid;
    t_result          r_out;

    // A new request may start when the sequencer is idle and the output
    // register is free or being drained in this cycle.
    assign o_stall = busy || (r_out_valid && i_stall);
    assign start   = i_valid && !o_stall;

    sle_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_req_type    (i_req_type),
        .i_position    (i_position),
        .i_value       (i_value),
        .i_replacement (i_replacement),
        .i_rdata       (rdata),
        .o_mem         (mem_req),
        .o_busy        (busy),
        .o_done        (done),
        .o_result      (res)
    );

    sle_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    // Output register: loaded on completion, which only happens after a
    // start that found the register free or draining.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (done) begin
            r_out <= res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out.status;
    assign o_read_value = r_out.read_value;
    assign o_length     = r_out.length;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (!r_out_valid || !i_stall)) else $error("result overrun");
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> o_stall) else $error("accepted while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> busy) else $error("start without work");
endmodule

[dv/tb_sequential_list_engine.sv]
// Self-checking testbench for the sequential list engine.
// Depends on sle_pkg and the sequential_list_engine top level only.
module tb_sequential_list_engine;
    import sle_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [3:0]         i_req_type;
    logic [5:0]         i_position;
    logic signed [31:0] i_value;
    logic signed [31:0] i_replacement;
    logic               o_valid;
    logic               i_stall;
    logic [2:0]         o_status;
    logic signed [31:0] o_read_value;
    logic [6:0]         o_length;

    sequential_list_engine u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_position(i_position), .i_value(i_value),
        .i_replacement(i_replacement), .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_read_value(o_read_value), .o_length(o_length)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Shadow copy of the list contents and count.
    logic signed [31:0] list_mem [Depth];
    int                 list_len;
    t_result            pending_results [$];
    int                 mismatch_count;
    bit                 idle_enable;
    bit                 sink_stall_enable;
    // Random traffic inserts below this length and removes at or above it.
    int                 fill_bias;

    // Computes the result of one request and updates the shadow list.
    function automatic t_result apply_request(logic [3:0] req, logic [5:0] pos,
                                              logic signed [31:0] val,
                                              logic signed [31:0] rep);
        t_result            r;
        int                 k;
        int                 hit;
        logic signed [31:0] t;
        r.status = ST_OK;
        r.read_value = '0;
        hit = -1;
        if (req == REQ_SET_BY_VAL || req == REQ_FIND) begin
            for (k = 0; k < list_len; k++) begin
                if (hit < 0 && list_mem[k] == val) hit = k;
            end
        end
        case (req)
            REQ_PUSH_BACK: begin
                if (list_len >= Depth) r.status = ST_FULL;
                else begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            REQ_PUSH_FRONT: begin
                if (list_len >= Depth) r.status = ST_FULL;
                else begin
                    for (k = list_len; k > 0; k--) list_mem[k] = list_mem[k-1];
                    list_mem[0] = val;
                    list_len++;
                end
            end
            REQ_POP_BACK: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len--;
            end
            REQ_POP_HEAD: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else begin
                    for (k = 0; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            end
            REQ_CLEAR: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len = 0;
            end
            REQ_SORT: begin
                for (int a = 0; a + 1 < list_len; a++) begin
                    for (int b = 0; b + 1 < list_len - a; b++) begin
                        if (list_mem[b] > list_mem[b+1]) begin
                            t = list_mem[b];
                            list_mem[b] = list_mem[b+1];
                            list_mem[b+1] = t;
                        end
                    end
                end
            end
            REQ_REVERSE: begin
                for (k = 0; k < list_len / 2; k++) begin
                    t = list_mem[k];
                    list_mem[k] = list_mem[list_len-1-k];
                    list_mem[list_len-1-k] = t;
                end
            end
            REQ_SET_AT: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else if (pos >= list_len) r.status = ST_BADPOS;
                else list_mem[pos] = val;
            end
            REQ_SET_BY_VAL: begin
                if (hit >= 0) list_mem[hit] = rep;
                else r.status = ST_NOTFOUND;
            end
            REQ_READ_AT: begin
                if (pos >= list_len) r.status = ST_BADPOS;
                else r.read_value = list_mem[pos];
            end
            REQ_FIND: begin
                if (hit >= 0) r.read_value = list_mem[hit];
                else r.status = ST_NOTFOUND;
            end
            default: ;
        endcase
        r.length = 7'(list_len);
        return r;
    endfunction

    // Sends one request transfer, with an optional random gap before it.
    // Valid stays high after the transfer until the next request or an idle
    // gap replaces it; the engine is busy in between, so nothing repeats.
    task automatic send_request(logic [3:0] req, logic [5:0] pos,
                                logic signed [31:0] val, logic signed [31:0] rep);
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_position    <= pos;
        i_value       <= val;
        i_replacement <= rep;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(apply_request(req, pos, val, rep));
        @(negedge i_clk);
    endtask

    // Stall generator for the result channel, in random bursts.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_stall_enable && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Result checker: every result transfer is compared with the oldest
    // expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d value %0d length %0d",
                             o_status, o_read_value, o_length);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_status !== want.status || o_read_value !== want.read_value
                    || o_length !== want.length) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.status, $signed(want.read_value), want.length,
                                 o_status, o_read_value, o_length);
                end
            end
        end
    end

    // Values drawn from a small pool so that finds and compares hit often,
    // with extremes and fully random words mixed in.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2, 3:    return 32'($signed($urandom_range(0, 15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // Picks a present element most of the time, so searches usually match.
    function automatic logic signed [31:0] pick_present();
        if (list_len > 0 && $urandom_range(0, 3) != 0)
            return list_mem[$urandom_range(0, list_len - 1)];
        return pick_value();
    endfunction

    task automatic test_empty_cases();
        send_request(REQ_POP_BACK, '0, 0, 0);
        send_request(REQ_POP_HEAD, '0, 0, 0);
        send_request(REQ_CLEAR, '0, 0, 0);
        send_request(REQ_SORT, '0, 0, 0);
        send_request(REQ_REVERSE, '0, 0, 0);
        send_request(REQ_SET_AT, '0, 5, 0);
        send_request(REQ_READ_AT, '0, 0, 0);
        send_request(REQ_FIND, '0, 0, 0);
        send_request(REQ_SET_BY_VAL, '0, 0, 1);
        send_request(REQ_LENGTH, '0, 0, 0);
        send_request(4'd12, 6'h3f, -1, -1);
        send_request(4'd15, '0, 0, 0);
    endtask

    task automatic test_each_request();
        send_request(REQ_PUSH_BACK, '0, 32'sh7fffffff, 0);
        send_request(REQ_SORT, '0, 0, 0);
        send_request(REQ_PUSH_FRONT, '0, 32'sh80000000, 0);
        send_request(REQ_PUSH_BACK, '0, -1, 0);
        send_request(REQ_SORT, '0, 0, 0);
        send_request(REQ_REVERSE, '0, 0, 0);
        send_request(REQ_SET_AT, 6'd2, 32'sh55555555, 0);
        send_request(REQ_SET_AT, 6'd3, 0, 0);
        send_request(REQ_SET_BY_VAL, '0, -1, 32'shaaaaaaaa);
        send_request(REQ_FIND, '0, 32'shaaaaaaaa, 0);
        send_request(REQ_READ_AT, 6'd3, 0, 0);
        send_request(REQ_READ_AT, 6'd2, 0, 0);
        send_request(REQ_POP_HEAD, '0, 0, 0);
        send_request(REQ_CLEAR, '0, 0, 0);
    endtask

    // Fills the list to the top, checks full rejects, then reads, sets, reverses, sorts, finds and drains.
    task automatic test_full_list();
        for (int k = 0; k < Depth; k++)
            send_request(($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT), '0,
                         $urandom, 0);
        send_request(REQ_PUSH_BACK, '0, 1, 0);
        send_request(REQ_PUSH_FRONT, '0, 1, 0);
        send_request(REQ_READ_AT, 6'd63, 0, 0);
        send_request(REQ_SET_AT, 6'd63, -5, 0);
        send_request(REQ_REVERSE, '0, 0, 0);
        send_request(REQ_SORT, '0, 0, 0);
        send_request(REQ_FIND, '0, -5, 0);
        for (int k = 0; k < Depth; k++)
            send_request(($urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_HEAD), '0, 0, 0);
    endtask

    // Random requests, weighted toward inserts while the list is short and
    // toward removals while it is long, so the count sweeps its whole range.
    task automatic test_random_requests(int n_items);
        logic [3:0] req;
        int         roll;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                req = (list_len < fill_bias) ? REQ_PUSH_BACK : REQ_POP_BACK;
            else if (roll < 40)
                req = (list_len < fill_bias) ? REQ_PUSH_FRONT : REQ_POP_HEAD;
            else if (roll < 42)
                req = REQ_SORT;
            else if (roll < 43)
                req = REQ_CLEAR;
            else if (roll < 45)
                req = 4'($urandom_range(12, 15));
            else
                req = 4'($urandom_range(0, 11));
            if ($urandom_range(0, 15) == 0) fill_bias = $urandom_range(0, Depth + 4);
            send_request(req,
                         ($urandom_range(0, 3) == 0 || list_len == 0) ? 6'($urandom)
                             : 6'($urandom_range(0, list_len - 1)),
                         (req == REQ_FIND || req == REQ_SET_BY_VAL) ? pick_present()
                             : pick_value(),
                         pick_value());
        end
    endtask

    initial begin : limit
        #100000000;
        $display("sequential_list_engine: mismatch");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req_type = '0;
        i_position = '0;
        i_value = '0;
        i_replacement = '0;
        list_len = 0;
        mismatch_count = 0;
        idle_enable = 1'b1;
        sink_stall_enable = 1'b1;
        fill_bias = 20;
        for (int k = 0; k < Depth; k++) list_mem[k] = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_empty_cases();
        test_each_request();
        test_full_list();
        test_random_requests(1150);
        // Back-to-back traffic at the end.
        idle_enable = 1'b0;
        sink_stall_enable = 1'b0;
        test_random_requests(300);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("sequential_list_engine: match");
        else
            $display("sequential_list_engine: mismatch");
        $finish;
    end
endmodule

[sequential_list_engine.f]
rtl/core/sle_pkg.sv
rtl/core/sle_store.sv
rtl/core/sle_seq.sv
rtl/core/sequential_list_engine.sv
dv/tb_sequential_list_engine.sv
